FILE: sv/assert_macros.svh
// Assertion macros used by the top level of the depacketizer.
// Each macro expects the clock aclk and the active-low reset aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: sv/h264fua_pkg.sv
// Types and constants of the H.264 FU-A to length-prefixed sample writer.
// Used by the per-byte step logic and by the top level; no dependencies.
package h264fua_pkg;

    localparam int SAMPLE_BYTES = 1048576;
    localparam int PTR_W        = $clog2(SAMPLE_BYTES + 1);
    localparam int FRAG_W       = (PTR_W > 16) ? PTR_W : 16;
    localparam int ADDR_W       = 20;
    localparam int SLEN_W       = 21;
    localparam int DUR_W        = 31;
    localparam int MAX_RES      = 3;

    localparam logic [PTR_W-1:0] CAP = PTR_W'(SAMPLE_BYTES);

    // NAL unit types of interest.
    localparam logic [4:0] NAL_IDR  = 5'd5;
    localparam logic [4:0] NAL_SPS  = 5'd7;
    localparam logic [4:0] NAL_PPS  = 5'd8;
    localparam logic [4:0] NAL_FU_A = 5'd28;

    // Result kinds.
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_WORD = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // Bit positions in packet_flags.
    localparam int FLAG_FU   = 0;
    localparam int FLAG_END  = 1;
    localparam int FLAG_IDR  = 2;
    localparam int FLAG_OPEN = 3;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        first_byte;
        logic [15:0] packet_length;
        logic        marker;
        logic [31:0] timestamp;
    } item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] address;
        logic [31:0]       write_value;
        logic [SLEN_W-1:0] sample_length;
        logic              keyframe;
        logic [DUR_W-1:0]  duration;
        logic              overflow;
    } result_t;

    typedef struct packed {
        logic [PTR_W-1:0]  write_pointer;
        logic [FRAG_W-1:0] fragment_length;
        logic [15:0]       byte_count;
        logic [7:0]        indicator_bits;
        logic [3:0]        packet_flags;
        logic [1:0]        parameter_sets_seen;
        logic [31:0]       previous_time;
        logic              overflow_seen;
    } state_t;

    // Results caused by one payload byte, at most the first three, in order, res[0] first.
    typedef struct packed {
        logic [1:0]            count;
        result_t [MAX_RES-1:0] res;
    } bundle_t;

endpackage

FILE: sv/h264_fua_to_length_prefixed.sv
// Top level of the H.264 FU-A to length-prefixed sample writer.
// Depends on h264fua_pkg, h264fua_step and assert_macros.svh.
`include "assert_macros.svh"

// Takes one RTP H.264 payload byte per request and issues byte writes, length
// word writes and sample-complete results for an external sample memory. A
// byte is registered, then processed by the step logic once the queue has
// room; its results (zero to three), if any, are pushed as one entry into a
// four-entry result queue, which delivers one result per cycle while m_tready
// is high. One byte is accepted every cycle while the queue has room, so plain
// payload bytes sustain one per cycle; bytes that start a NAL unit yield two
// results, and a closing byte may add a length patch and a sample-complete
// result. A byte's results pass through the input register and the queue.
module h264_fua_to_length_prefixed (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [55:0]   s_tdata,   // payload_byte, packet_length, timestamp
    input  logic [1:0]    s_tuser,   // first_byte, marker
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [111:0]  m_tdata,   // address, write_value, sample_length,
                                     // keyframe, duration, overflow, zero fill
    output logic [1:0]    m_tuser    // kind
);
    import h264fua_pkg::*;

    localparam int DEPTH  = 4;
    localparam int QPTR_W = $clog2(DEPTH);
    localparam int QCNT_W = $clog2(DEPTH + 1);

    logic    in_valid_reg;
    item_t   in_item_reg;
    state_t  state_reg, state_next;
    bundle_t bundle;
    logic    fire;

    bundle_t             queue_mem [DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [1:0]          sub_reg;
    logic                push, pop, out_fire;
    bundle_t             head;
    result_t             cur;

    assign fire     = in_valid_reg && (count_reg < QCNT_W'(DEPTH));
    assign s_tready = !in_valid_reg || fire;
    assign push     = fire && (bundle.count != 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.payload_byte  <= s_tdata[7:0];
            in_item_reg.packet_length <= s_tdata[23:8];
            in_item_reg.timestamp     <= s_tdata[55:24];
            in_item_reg.first_byte    <= s_tuser[0];
            in_item_reg.marker        <= s_tuser[1];
        end
    end

    h264fua_step u_step (
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .bundle     (bundle)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    // Result queue: one entry per byte with results, drained one result at a time.
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= bundle;
        end
    end

    assign head     = queue_mem[rd_ptr_reg];
    assign cur      = head.res[sub_reg];
    assign m_tvalid = (count_reg != '0);
    assign out_fire = m_tvalid && m_tready;
    assign pop      = out_fire && (sub_reg == head.count - 2'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)      count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push) count_reg <= count_reg - QCNT_W'(1);
            if (pop)           sub_reg <= 2'd0;
            else if (out_fire) sub_reg <= sub_reg + 2'd1;
        end
    end

    assign m_tdata = {6'd0, cur.overflow, cur.duration, cur.keyframe, cur.sample_length,
                      cur.write_value, cur.address};
    assign m_tuser = cur.kind;

    `ASSERT_ALWAYS(a_queue_bound, count_reg <= QCNT_W'(DEPTH), "result queue overfilled")
    `ASSERT_ALWAYS(a_pointer_cap, state_reg.write_pointer <= CAP, "write pointer past capacity")
    `ASSERT_IMPLIES(a_sub_in_entry, m_tvalid, sub_reg < head.count, "result index outside entry")
    `ASSERT_IMPLIES(a_stall_cause, !s_tready, in_valid_reg && !fire, "input stalled while free")

endmodule

FILE: sv/h264fua_step.sv
// Per-byte step of the depacketizer: next state and the writes one byte causes.
// Purely combinational; depends on h264fua_pkg.
module h264fua_step (
    input  h264fua_pkg::state_t  state,
    input  h264fua_pkg::item_t   item,
    output h264fua_pkg::state_t  state_next,
    output h264fua_pkg::bundle_t bundle
);
    import h264fua_pkg::*;

    function automatic logic fits(input logic [PTR_W-1:0] wp, input logic [2:0] size);
        fits = (wp <= CAP) && ((CAP - wp) >= PTR_W'(size));
    endfunction

    function automatic result_t mk_write(input logic [1:0] kind,
                                         input logic [ADDR_W-1:0] addr,
                                         input logic [31:0] value);
        result_t r;
        r.kind          = kind;
        r.address       = addr;
        r.write_value   = value;
        r.sample_length = '0;
        r.keyframe      = 1'b0;
        r.duration      = DUR_W'(1);
        r.overflow      = 1'b0;
        mk_write = r;
    endfunction

    logic [15:0]       len_eff;
    logic              active;
    logic [15:0]       idx;
    logic              last;
    logic [4:0]        nal;
    logic              a_want, b_want;
    logic [2:0]        a_size;
    logic [31:0]       a_val;
    logic [7:0]        b_val;
    logic [PTR_W-1:0]  wp;
    logic              ovf;
    logic [3:0]        flags;
    logic [FRAG_W-1:0] frag;
    logic [FRAG_W:0]   patch_base;
    logic [31:0]       diff;
    logic [3:0]        cand_v;
    result_t [3:0]     cand;

    always_comb begin
        state_next = state;
        cand_v     = '0;
        cand       = '0;
        a_want     = 1'b0;
        b_want     = 1'b0;
        a_size     = 3'd1;
        a_val      = '0;
        b_val      = '0;
        nal        = item.payload_byte[4:0];
        flags      = state.packet_flags;
        frag       = state.fragment_length;
        diff       = item.timestamp - state.previous_time;
        patch_base = '0;

        len_eff = (item.packet_length == 16'd0) ? 16'd1 : item.packet_length;
        active  = item.first_byte || (state.byte_count != 16'd0);
        idx     = item.first_byte ? 16'd0 : state.byte_count;
        last    = ({1'b0, idx} + 17'd1) >= {1'b0, len_eff};

        if (active) begin
            if (idx == 16'd0) begin
                flags = flags & (4'b1 << FLAG_OPEN);
                if (nal == NAL_FU_A) begin
                    flags[FLAG_FU]            = 1'b1;
                    state_next.indicator_bits = item.payload_byte;
                end else begin
                    if (nal == NAL_IDR) flags[FLAG_IDR] = 1'b1;
                    if (nal == NAL_SPS) begin
                        state_next.parameter_sets_seen[0] = 1'b1;
                    end else if (nal == NAL_PPS && state.parameter_sets_seen[0]) begin
                        state_next.parameter_sets_seen[1] = 1'b1;
                    end
                    a_want = 1'b1;
                    a_size = 3'd4;
                    a_val  = {16'd0, len_eff};
                    b_want = 1'b1;
                    b_val  = item.payload_byte;
                end
            end else if (flags[FLAG_FU]) begin
                if (idx == 16'd1) begin
                    // FU header: the start bit opens a joined unit.
                    if (nal == NAL_IDR) flags[FLAG_IDR] = 1'b1;
                    if (item.payload_byte[7]) begin
                        a_want = 1'b1;
                        a_size = 3'd4;
                        a_val  = {16'd0, len_eff - 16'd1};
                        b_want = 1'b1;
                        b_val  = {state.indicator_bits[7:5] & 3'b011, nal};
                        frag   = FRAG_W'(len_eff - 16'd1);
                        flags[FLAG_OPEN] = 1'b1;
                    end else if (item.payload_byte[6]) begin
                        flags[FLAG_END] = 1'b1;
                    end
                end else begin
                    a_want = 1'b1;
                    a_val  = {24'd0, item.payload_byte};
                    if (flags[FLAG_OPEN] && ({1'b0, frag} < (FRAG_W + 1)'(SAMPLE_BYTES))) begin
                        frag = frag + FRAG_W'(1);
                    end
                end
            end else begin
                a_want = 1'b1;
                a_val  = {24'd0, item.payload_byte};
            end
        end

        // Writes take effect in order; the second sees the first's pointer.
        wp  = state.write_pointer;
        ovf = state.overflow_seen;
        if (a_want) begin
            if (fits(wp, a_size)) begin
                cand_v[0] = 1'b1;
                cand[0]   = mk_write((a_size == 3'd4) ? KIND_WORD : KIND_BYTE,
                                     ADDR_W'(wp), a_val);
                wp        = wp + PTR_W'(a_size);
            end else begin
                ovf = 1'b1;
                wp  = CAP;
            end
        end
        if (b_want) begin
            if (fits(wp, 3'd1)) begin
                cand_v[1] = 1'b1;
                cand[1]   = mk_write(KIND_BYTE, ADDR_W'(wp), {24'd0, b_val});
                wp        = wp + PTR_W'(1);
            end else begin
                ovf = 1'b1;
                wp  = CAP;
            end
        end

        // End fragment: patch the length word written at the start.
        if (active && last && flags[FLAG_END] && flags[FLAG_OPEN]) begin
            flags[FLAG_OPEN] = 1'b0;
            patch_base = {1'b0, frag} + (FRAG_W + 1)'(4);
            if (!ovf && ({1'b0, frag} <= (FRAG_W + 1)'(SAMPLE_BYTES))
                    && ((FRAG_W + 1)'(wp) >= patch_base)) begin
                cand_v[2] = 1'b1;
                cand[2]   = mk_write(KIND_WORD,
                                     ADDR_W'((FRAG_W + 1)'(wp) - patch_base),
                                     32'(frag));
            end
        end

        if (active && last && item.marker && (state_next.parameter_sets_seen == 2'b11)) begin
            cand_v[3]             = 1'b1;
            cand[3].kind          = KIND_DONE;
            cand[3].address       = '0;
            cand[3].write_value   = '0;
            cand[3].sample_length = SLEN_W'(wp);
            cand[3].keyframe      = flags[FLAG_IDR];
            cand[3].duration      = (diff == 32'd0 || diff[31]) ? DUR_W'(1) : diff[DUR_W-1:0];
            cand[3].overflow      = ovf;
            state_next.previous_time = item.timestamp;
            wp               = '0;
            ovf              = 1'b0;
            flags[FLAG_OPEN] = 1'b0;
        end

        if (active) begin
            state_next.write_pointer   = wp;
            state_next.overflow_seen   = ovf;
            state_next.packet_flags    = flags;
            state_next.fragment_length = frag;
            state_next.byte_count      = last ? 16'd0 : idx + 16'd1;
        end
    end

    // Pack the candidate results into consecutive slots.
    logic [1:0] n;
    logic       full;

    always_comb begin
        bundle.res = '0;
        n          = 2'd0;
        full       = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (cand_v[i] && !full) begin
                bundle.res[n] = cand[i];
                if (n == 2'd2) full = 1'b1;
                else           n    = n + 2'd1;
            end
        end
        bundle.count = full ? 2'd3 : n;
    end

endmodule

FILE: test/fua_sample_checker.sv
// Checker for the H.264 FU-A to length-prefixed sample writer. It watches both stream
// channels, predicts the memory commands that each request causes and compares them.
// Depends on h264fua_pkg for the result type, the command kinds, the NAL types and CAP.
`timescale 1ns / 1ps

module fua_sample_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [55:0]  s_tdata,   // payload_byte, packet_length, timestamp
    input  logic [1:0]   s_tuser,   // first_byte, marker
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [111:0] m_tdata,   // address, write_value, sample_length,
                                    // keyframe, duration, overflow, zero fill
    input  logic [1:0]   m_tuser,   // kind
    output int           mismatches,
    output int           cmds_due,
    output int           cmds_checked,
    output int           samples_closed,
    output int           bytes_used,
    output int           bytes_ignored
);
    import h264fua_pkg::*;

    // Own copy of the writer state.
    logic [PTR_W-1:0]  wr_ptr;
    logic [FRAG_W-1:0] unit_len;
    logic [15:0]       byte_idx;
    logic [7:0]        fu_indicator;
    logic              pkt_is_fu;
    logic              pkt_ends_unit;
    logic              pkt_is_idr;
    logic              unit_open;
    logic              sps_seen;
    logic              pps_seen;
    logic [31:0]       last_sample_ms;
    logic              dropped;

    result_t mem_cmds_due[$];

    task automatic queue_cmd(input logic [1:0] kind, input logic [31:0] addr,
                             input logic [31:0] value, input logic [31:0] slen,
                             input logic is_key, input logic [31:0] dur, input logic ovf);
        result_t r;
        r.kind          = kind;
        r.address       = addr[ADDR_W-1:0];
        r.write_value   = value;
        r.sample_length = slen[SLEN_W-1:0];
        r.keyframe      = is_key;
        r.duration      = dur[DUR_W-1:0];
        r.overflow      = ovf;
        mem_cmds_due.push_back(r);
    endtask

    // A write that does not fit wholly below capacity is dropped and pins the pointer there.
    task automatic store_write(input int unsigned size, input logic [31:0] value);
        if (32'(wr_ptr) <= 32'(CAP) && 32'(CAP) - 32'(wr_ptr) >= size) begin
            queue_cmd(size == 4 ? KIND_WORD : KIND_BYTE, 32'(wr_ptr), value, 32'd0, 1'b0,
                      32'd1, 1'b0);
            wr_ptr = wr_ptr + size[PTR_W-1:0];
        end else begin
            dropped = 1'b1;
            wr_ptr  = CAP;
        end
    endtask

    task automatic depacketize_byte(input logic [7:0] pb, input logic first,
                                    input logic [15:0] plen, input logic mk,
                                    input logic [31:0] ts);
        int unsigned len;
        int unsigned idx;
        logic        last;
        logic [4:0]  nal;
        logic [31:0] gap;
        logic [31:0] patch_at;
        len = (plen == 16'd0) ? 1 : plen;
        if (!first && byte_idx == 16'd0) begin
            bytes_ignored++;
        end else begin
            bytes_used++;
            idx  = first ? 0 : byte_idx;
            last = (idx + 1 >= len);
            if (idx == 0) begin
                nal           = pb[4:0];
                pkt_is_fu     = 1'b0;
                pkt_ends_unit = 1'b0;
                pkt_is_idr    = 1'b0;
                if (nal == NAL_FU_A) begin
                    pkt_is_fu    = 1'b1;
                    fu_indicator = pb;
                end else begin
                    if (nal == NAL_IDR)
                        pkt_is_idr = 1'b1;
                    if (nal == NAL_SPS)
                        sps_seen = 1'b1;
                    else if (nal == NAL_PPS && sps_seen)
                        pps_seen = 1'b1;
                    store_write(4, len);
                    store_write(1, {24'd0, pb});
                end
            end else if (pkt_is_fu) begin
                if (idx == 1) begin
                    nal = pb[4:0];
                    if (nal == NAL_IDR)
                        pkt_is_idr = 1'b1;
                    if (pb[7]) begin
                        // Start fragment: provisional length, then the rebuilt NAL header.
                        store_write(4, len - 1);
                        store_write(1, {24'd0, 1'b0, fu_indicator[6:5], nal});
                        unit_len  = FRAG_W'(len - 1);
                        unit_open = 1'b1;
                    end else if (pb[6]) begin
                        pkt_ends_unit = 1'b1;
                    end
                end else begin
                    store_write(1, {24'd0, pb});
                    if (unit_open && unit_len < CAP)
                        unit_len = unit_len + 1'b1;
                end
            end else begin
                store_write(1, {24'd0, pb});
            end

            if (last && pkt_ends_unit && unit_open) begin
                unit_open = 1'b0;
                // The length word is not patched once the sample has lost writes.
                if (!dropped && unit_len <= CAP && 32'(wr_ptr) >= 32'(unit_len) + 32'd4) begin
                    patch_at = 32'(wr_ptr) - 32'(unit_len) - 32'd4;
                    queue_cmd(KIND_WORD, patch_at, 32'(unit_len), 32'd0, 1'b0, 32'd1, 1'b0);
                end
            end

            if (last && mk && sps_seen && pps_seen) begin
                gap = ts - last_sample_ms;
                queue_cmd(KIND_DONE, 32'd0, 32'd0, 32'(wr_ptr), pkt_is_idr,
                          (gap == 32'd0 || gap[31]) ? 32'd1 : gap, dropped);
                samples_closed++;
                last_sample_ms = ts;
                wr_ptr         = '0;
                dropped        = 1'b0;
                unit_open      = 1'b0;
            end

            byte_idx = last ? 16'd0 : 16'(idx + 1);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : watch
        result_t want;
        if (!aresetn) begin
            wr_ptr         = '0;
            unit_len       = '0;
            byte_idx       = '0;
            fu_indicator   = '0;
            pkt_is_fu      = 1'b0;
            pkt_ends_unit  = 1'b0;
            pkt_is_idr     = 1'b0;
            unit_open      = 1'b0;
            sps_seen       = 1'b0;
            pps_seen       = 1'b0;
            last_sample_ms = '0;
            dropped        = 1'b0;
            mem_cmds_due.delete();
        end else begin
            if (s_tvalid && s_tready)
                depacketize_byte(s_tdata[7:0], s_tuser[0], s_tdata[23:8], s_tuser[1],
                                 s_tdata[55:24]);
            if (m_tvalid && m_tready) begin
                cmds_checked++;
                if (mem_cmds_due.size() == 0) begin
                    $error("result of kind %0d at address 0x%0h with none expected",
                           m_tuser, m_tdata[19:0]);
                    mismatches++;
                end else begin
                    want = mem_cmds_due.pop_front();
                    check_field("kind", 32'(want.kind), 32'(m_tuser));
                    check_field("address", 32'(want.address), 32'(m_tdata[19:0]));
                    check_field("write_value", want.write_value, m_tdata[51:20]);
                    check_field("sample_length", 32'(want.sample_length), 32'(m_tdata[72:52]));
                    check_field("keyframe", 32'(want.keyframe), 32'(m_tdata[73]));
                    check_field("duration", 32'(want.duration), 32'(m_tdata[104:74]));
                    check_field("overflow", 32'(want.overflow), 32'(m_tdata[105]));
                end
            end
        end
        cmds_due = mem_cmds_due.size();
    end

endmodule

FILE: test/tb_h264_fua_to_length_prefixed.sv
// Testbench top of the H.264 FU-A to length-prefixed sample writer: drives payload
// bytes and result back-pressure, and gives the verdict from the checker's counts.
// Depends on h264fua_pkg, the block h264_fua_to_length_prefixed and fua_sample_checker.
`timescale 1ns / 1ps

module tb_h264_fua_to_length_prefixed;
    import h264fua_pkg::*;

    localparam int ITEMS          = 180;
    localparam int CYCLE_LIMIT    = 2000000;
    localparam int RX_HOLD_CYCLES = 200;
    localparam logic [4:0] NAL_SLICE = 5'd1;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [55:0]  s_tdata;   // payload_byte, packet_length, timestamp
    logic [1:0]   s_tuser;   // first_byte, marker
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;   // address, write_value, sample_length, keyframe, duration,
                             // overflow, zero fill
    logic [1:0]   m_tuser;   // kind

    int mismatches;
    int cmds_due;
    int cmds_checked;
    int samples_closed;
    int bytes_used;
    int bytes_ignored;
    int cycles;

    bit          idle_on;
    bit          hold_rx;
    logic [31:0] media_ms;
    logic [7:0]  nal_bytes[$];

    h264_fua_to_length_prefixed dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    fua_sample_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatches     (mismatches),
        .cmds_due       (cmds_due),
        .cmds_checked   (cmds_checked),
        .samples_closed (samples_closed),
        .bytes_used     (bytes_used),
        .bytes_ignored  (bytes_ignored)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $error("run did not finish within %0d cycles", CYCLE_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off when asked for.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_rx) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge aclk);
                hold_rx = 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic offer(input logic [7:0] pb, input logic first, input logic [15:0] plen,
                         input logic mk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {media_ms, plen, pb};
        s_tuser  <= {mk, first};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_packet(input int plen, input logic mk);
        foreach (nal_bytes[i])
            offer(nal_bytes[i], i == 0, plen[15:0], mk);
    endtask

    task automatic send_single(input logic [4:0] nal, input int n, input logic mk);
        nal_bytes.delete();
        nal_bytes.push_back({3'($urandom), nal});
        repeat (n - 1) nal_bytes.push_back(8'($urandom));
        send_packet(n, mk);
    endtask

    // One NAL unit split into FU-A fragments; a single fragment carries start and end.
    task automatic send_fua(input logic [4:0] nal, input int frags, input logic mk);
        logic [7:0] indicator;
        int         k;
        indicator = {3'($urandom), NAL_FU_A};
        for (k = 0; k < frags; k++) begin
            nal_bytes.delete();
            nal_bytes.push_back(indicator);
            nal_bytes.push_back({1'(k == 0), 1'(k == frags - 1), 1'($urandom), nal});
            repeat ($urandom_range(0, 8)) nal_bytes.push_back(8'($urandom));
            send_packet(nal_bytes.size(), mk && k == frags - 1);
        end
    endtask

    task automatic send_access_unit();
        int         units;
        int         k;
        logic [4:0] nal;
        logic       is_key;
        if ($urandom_range(0, 15) == 0)
            media_ms = $urandom;
        else
            media_ms = media_ms + $urandom_range(0, 40);
        if ($urandom_range(0, 3) == 0)
            send_single(NAL_SPS, $urandom_range(1, 6), 1'b0);
        if ($urandom_range(0, 3) == 0)
            send_single(NAL_PPS, $urandom_range(1, 6), 1'b0);
        units  = $urandom_range(1, 3);
        is_key = ($urandom_range(0, 2) == 0);
        for (k = 0; k < units; k++) begin
            if (k == 0 && is_key) begin
                nal = NAL_IDR;
            end else begin
                do nal = 5'($urandom); while (nal == NAL_FU_A);
            end
            if ($urandom_range(0, 1) == 0)
                send_single(nal, $urandom_range(1, 12), k == units - 1);
            else
                send_fua(nal, $urandom_range(1, 4), k == units - 1);
        end
    endtask

    // Broken traffic: strays, packets left open, packets ended early, lost starts.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        nal_bytes.delete();
        repeat (n) nal_bytes.push_back(8'($urandom));
        case ($urandom_range(0, 3))
            0: offer(nal_bytes[0], 1'b0, 16'($urandom), 1'($urandom));
            1: send_packet(n + $urandom_range(1, 300), 1'($urandom));
            2: send_packet($urandom_range(0, n - 1), 1'($urandom));
            default: begin
                nal_bytes[0] = {nal_bytes[0][7:5], NAL_FU_A};
                if (n > 1)
                    nal_bytes[1][7] = 1'b0;
                send_packet(n, 1'($urandom));
            end
        endcase
    endtask

    initial begin
        int  target;
        int  start;
        bit  held;
        bit  paused;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        aresetn  = 1'b0;
        idle_on  = 1'b1;
        hold_rx  = 1'b0;
        media_ms = '0;
        held     = 1'b0;
        paused   = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part.
        offer(8'hA5, 1'b0, 16'd4, 1'b0);            // no packet open: ignored
        nal_bytes.delete();
        nal_bytes.push_back(8'h00);
        send_packet(1, 1'b0);
        nal_bytes.delete();
        nal_bytes.push_back(8'hFF);
        nal_bytes.push_back(8'hFF);
        send_packet(2, 1'b1);                        // marker before any parameter set
        send_single(NAL_PPS, 2, 1'b0);               // a PPS before the SPS does not count
        send_single(NAL_SPS, 3, 1'b0);
        send_single(NAL_PPS, 2, 1'b0);
        media_ms = 32'hFFFF_FFF0;
        send_single(NAL_IDR, 2, 1'b1);               // time went backwards: duration 1
        send_fua(NAL_IDR, 1, 1'b1);                  // start and end together, same time
        media_ms = 32'd0;
        nal_bytes.delete();
        nal_bytes.push_back({3'b011, NAL_FU_A});
        send_packet(1, 1'b0);                        // FU-A of one byte writes nothing
        nal_bytes.delete();
        nal_bytes.push_back({3'b010, NAL_FU_A});
        nal_bytes.push_back({3'b010, NAL_SLICE});
        nal_bytes.push_back(8'hAB);
        send_packet(3, 1'b0);                        // end fragment without a start
        nal_bytes.delete();
        nal_bytes.push_back({3'b000, NAL_SLICE});
        nal_bytes.push_back(8'h22);
        nal_bytes.push_back(8'h33);
        send_packet(0, 1'b0);                        // length zero: the first byte ends it
        nal_bytes.delete();
        nal_bytes.push_back({3'b011, NAL_SLICE});
        nal_bytes.push_back(8'h11);
        send_packet(65535, 1'b0);                    // abandoned by the next packet
        media_ms = 32'h7FFF_FFEF;
        send_fua(NAL_SLICE, 3, 1'b1);                // largest positive duration
        media_ms = 32'hFFFF_FFFF;
        send_single(NAL_SLICE, 1, 1'b1);

        // Random part: mostly well-formed access units, some broken traffic.
        idle_on = 1'b1;
        start   = bytes_used;
        target  = ITEMS;
        while (bytes_used < target) begin
            if (!held && bytes_used >= start + 20) begin
                hold_rx = 1'b1;
                held    = 1'b1;
            end
            if (!paused && bytes_used >= start + 60) begin
                s_tvalid <= 1'b0;
                do @(negedge aclk); while (cmds_due != 0);
                paused = 1'b1;
            end
            if (bytes_used >= target - 40)
                idle_on = 1'b0;
            if ($urandom_range(0, 5) == 0)
                send_noise();
            else
                send_access_unit();
        end

        s_tvalid <= 1'b0;
        do @(negedge aclk); while (cmds_due != 0);
        repeat (10) @(negedge aclk);

        $display("Covered %0d payload bytes and %0d strays: %0d memory commands checked,",
                 bytes_used, bytes_ignored, cmds_checked);
        $display("%0d samples closed, with a long result hold-off and one full drain.",
                 samples_closed);
        if (cmds_due != 0)
            $error("%0d expected results never arrived", cmds_due);
        if (mismatches == 0 && cmds_due == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/h264fua_pkg.sv
sv/h264fua_step.sv
sv/h264_fua_to_length_prefixed.sv
test/fua_sample_checker.sv
test/tb_h264_fua_to_length_prefixed.sv
